@@ hdl/ultd_pkg.sv @@
// ----------------------------------------------------------------------------
// ultd_pkg
// Shared widths, register indexes, payload types and month length lookup for
// the UTC to local date and time converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ultd_pkg;

  localparam int YearW     = 7;
  localparam int MonthW    = 4;
  localparam int DayW      = 5;
  localparam int HourW     = 5;
  localparam int MinuteW   = 6;
  localparam int DstW      = 2;
  localparam int ZoneHourW = 5;
  localparam int ZoneMinW  = 6;
  localparam int CfgDataW  = 6;
  localparam int CfgIdxW   = 1;
  localparam int TotalW    = 7;

  localparam int MinPerHour  = 60;
  localparam int HoursPerDay = 24;
  localparam int YearSpan    = 100;
  localparam int LastMonth   = 12;
  localparam int LastDay     = 31;

  localparam logic [CfgIdxW-1:0] RegZoneHours   = 1'd0;
  localparam logic [CfgIdxW-1:0] RegZoneMinutes = 1'd1;

  typedef struct packed {
    logic [YearW-1:0]   utc_year;
    logic [MonthW-1:0]  utc_month;
    logic [DayW-1:0]    utc_day;
    logic [HourW-1:0]   utc_hour;
    logic [MinuteW-1:0] utc_minute;
    logic [DstW-1:0]    dst_offset;
  } utc_t;

  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic               fwd;
    logic               back;
    logic [DayW-1:0]    len;
    logic [DayW-1:0]    prev_len;
  } shift_t;

  typedef struct packed {
    logic [YearW-1:0]   local_year;
    logic [MonthW-1:0]  local_month;
    logic [DayW-1:0]    local_day;
    logic [HourW-1:0]   local_hour;
    logic [MinuteW-1:0] local_minute;
  } local_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (month)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ultd_if.sv @@
// ----------------------------------------------------------------------------
// ultd_req_if / ultd_res_if
// Valid/ready channels for UTC requests and local date and time results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ultd_req_if;
  logic                          valid;
  logic                          ready;
  logic [ultd_pkg::YearW-1:0]    utc_year;
  logic [ultd_pkg::MonthW-1:0]   utc_month;
  logic [ultd_pkg::DayW-1:0]     utc_day;
  logic [ultd_pkg::HourW-1:0]    utc_hour;
  logic [ultd_pkg::MinuteW-1:0]  utc_minute;
  logic signed [ultd_pkg::DstW-1:0] dst_offset;

  modport source (output valid, utc_year, utc_month, utc_day, utc_hour, utc_minute,
                  dst_offset, input ready);
  modport sink (input valid, utc_year, utc_month, utc_day, utc_hour, utc_minute,
                dst_offset, output ready);
endinterface

interface ultd_res_if;
  logic                          valid;
  logic                          ready;
  logic [ultd_pkg::YearW-1:0]    local_year;
  logic [ultd_pkg::MonthW-1:0]   local_month;
  logic [ultd_pkg::DayW-1:0]     local_day;
  logic [ultd_pkg::HourW-1:0]    local_hour;
  logic [ultd_pkg::MinuteW-1:0]  local_minute;

  modport source (output valid, local_year, local_month, local_day, local_hour,
                  local_minute, input ready);
  modport sink (input valid, local_year, local_month, local_day, local_hour,
                local_minute, output ready);
endinterface

`default_nettype wire

@@ hdl/ultd_time_add.sv @@
// ----------------------------------------------------------------------------
// ultd_time_add
// Two pipeline stages: minute sum with carry and year fold, then the hour
// total with day direction, local hour and month lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module ultd_time_add (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire ultd_pkg::utc_t                        in_data_i,
  input  wire logic [ultd_pkg::ZoneHourW-1:0]        zone_hours_i,
  input  wire logic [ultd_pkg::ZoneMinW-1:0]         zone_minutes_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output ultd_pkg::shift_t                           out_data_o
);

  typedef struct packed {
    logic [ultd_pkg::YearW-1:0]     year;
    logic [ultd_pkg::MonthW-1:0]    month;
    logic [ultd_pkg::DayW-1:0]      day;
    logic [ultd_pkg::HourW-1:0]     hour;
    logic [ultd_pkg::MinuteW-1:0]   minute;
    logic [1:0]                     carry;
    logic [ultd_pkg::DstW-1:0]      dst;
    logic [ultd_pkg::ZoneHourW-1:0] zone;
  } sum_t;

  localparam logic [ultd_pkg::MinuteW:0] OneHour  = 7'(ultd_pkg::MinPerHour);
  localparam logic [ultd_pkg::MinuteW:0] TwoHours = 7'(2 * ultd_pkg::MinPerHour);
  localparam logic [ultd_pkg::YearW-1:0] Span     = 7'(ultd_pkg::YearSpan);
  localparam logic [ultd_pkg::TotalW-1:0] OneDay  = 7'(ultd_pkg::HoursPerDay);
  localparam logic [ultd_pkg::TotalW-1:0] TwoDays = 7'(2 * ultd_pkg::HoursPerDay);

  logic                         s1_valid_q;
  sum_t                         s1_q;
  sum_t                         s1_d;
  logic                         s1_ready;
  logic                         s2_valid_q;
  ultd_pkg::shift_t             s2_q;
  ultd_pkg::shift_t             s2_d;
  logic                         s2_ready;
  logic [ultd_pkg::MinuteW:0]   msum;
  logic [ultd_pkg::TotalW-1:0]  total;
  logic                         leap;

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_comb begin
    msum = {1'b0, in_data_i.utc_minute} + {1'b0, zone_minutes_i};
    s1_d.year   = (in_data_i.utc_year >= Span) ? in_data_i.utc_year - Span
                                               : in_data_i.utc_year;
    s1_d.month  = in_data_i.utc_month;
    s1_d.day    = in_data_i.utc_day;
    s1_d.hour   = in_data_i.utc_hour;
    s1_d.dst    = in_data_i.dst_offset;
    s1_d.zone   = zone_hours_i;
    if (msum >= TwoHours) begin
      s1_d.carry  = 2'd2;
      s1_d.minute = ultd_pkg::MinuteW'(msum - TwoHours);
    end else if (msum >= OneHour) begin
      s1_d.carry  = 2'd1;
      s1_d.minute = ultd_pkg::MinuteW'(msum - OneHour);
    end else begin
      s1_d.carry  = 2'd0;
      s1_d.minute = ultd_pkg::MinuteW'(msum);
    end
  end

  always_comb begin
    total = {2'b00, s1_q.hour} + {{2{s1_q.zone[ultd_pkg::ZoneHourW-1]}}, s1_q.zone}
          + {5'b00000, s1_q.carry} + {{5{s1_q.dst[ultd_pkg::DstW-1]}}, s1_q.dst};
    leap          = (s1_q.year[1:0] == 2'b00);
    s2_d.year     = s1_q.year;
    s2_d.month    = s1_q.month;
    s2_d.day      = s1_q.day;
    s2_d.minute   = s1_q.minute;
    s2_d.back     = total[ultd_pkg::TotalW-1];
    s2_d.fwd      = !total[ultd_pkg::TotalW-1] && (total >= OneDay);
    s2_d.len      = ultd_pkg::month_len(s1_q.month, leap);
    s2_d.prev_len = ultd_pkg::month_len(s1_q.month - 4'd1, leap);
    if (s2_d.back) begin
      s2_d.hour = ultd_pkg::HourW'(total + OneDay);
    end else if (s2_d.fwd && (total >= TwoDays)) begin
      s2_d.hour = ultd_pkg::HourW'(total - TwoDays);
    end else if (s2_d.fwd) begin
      s2_d.hour = ultd_pkg::HourW'(total - OneDay);
    end else begin
      s2_d.hour = ultd_pkg::HourW'(total);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) s1_q <= s1_d;
    if (s2_ready && s1_valid_q) s2_q <= s2_d;
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_q;

endmodule

`default_nettype wire

@@ hdl/ultd_date_roll.sv @@
// ----------------------------------------------------------------------------
// ultd_date_roll
// Final stage: moves the date one day forward or back across month and year
// ends and holds the finished result for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ultd_date_roll (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ultd_pkg::shift_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ultd_pkg::local_t       out_data_o
);

  localparam logic [ultd_pkg::MonthW-1:0] Dec     = 4'(ultd_pkg::LastMonth);
  localparam logic [ultd_pkg::DayW-1:0]   LastDay = 5'(ultd_pkg::LastDay);
  localparam logic [ultd_pkg::YearW-1:0]  TopYear = 7'(ultd_pkg::YearSpan - 1);

  logic              res_valid_q;
  ultd_pkg::local_t  res_q;
  ultd_pkg::local_t  res_d;
  logic              ready;

  assign ready      = !res_valid_q || out_ready_i;
  assign in_ready_o = ready;

  always_comb begin
    res_d.local_year   = in_data_i.year;
    res_d.local_month  = in_data_i.month;
    res_d.local_day    = in_data_i.day;
    res_d.local_hour   = in_data_i.hour;
    res_d.local_minute = in_data_i.minute;
    if (in_data_i.fwd) begin
      if (in_data_i.day >= in_data_i.len) begin
        res_d.local_day = 5'd1;
        if (in_data_i.month >= Dec) begin
          res_d.local_month = 4'd1;
          res_d.local_year  = (in_data_i.year >= TopYear) ? 7'd0 : in_data_i.year + 7'd1;
        end else begin
          res_d.local_month = in_data_i.month + 4'd1;
        end
      end else begin
        res_d.local_day = in_data_i.day + 5'd1;
      end
    end else if (in_data_i.back) begin
      if (in_data_i.day <= 5'd1) begin
        if (in_data_i.month <= 4'd1) begin
          res_d.local_month = Dec;
          res_d.local_day   = LastDay;
          res_d.local_year  = (in_data_i.year == 7'd0) ? TopYear : in_data_i.year - 7'd1;
        end else if (in_data_i.month > Dec) begin
          res_d.local_month = Dec;
          res_d.local_day   = LastDay;
        end else begin
          res_d.local_month = in_data_i.month - 4'd1;
          res_d.local_day   = in_data_i.prev_len;
        end
      end else begin
        res_d.local_day = in_data_i.day - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (ready) begin
      res_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) res_q <= res_d;
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

@@ hdl/utc_to_local_date_time.sv @@
// ----------------------------------------------------------------------------
// utc_to_local_date_time
// Converts a UTC date and time to local date and time with zone and
// daylight-saving offsets, rolling the date across month and year ends.
// Each request is registered in the minute-sum, hour-total and date-roll stages before its result is valid.
// Throughput: one request per cycle; stages hold under back-pressure.
// Reset: clears all stage valid bits and sets both zone offsets to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module utc_to_local_date_time (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ultd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [ultd_pkg::CfgDataW-1:0]     cfg_data_i,
  ultd_req_if.sink                               req_i,
  ultd_res_if.source                             res_o
);

  logic [ultd_pkg::ZoneHourW-1:0] zone_hours_q;
  logic [ultd_pkg::ZoneMinW-1:0]  zone_minutes_q;
  ultd_pkg::utc_t                 req_data;
  logic                           mid_valid;
  logic                           mid_ready;
  ultd_pkg::shift_t               mid_data;
  ultd_pkg::local_t               res_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_hours_q   <= '0;
      zone_minutes_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ultd_pkg::RegZoneHours:   zone_hours_q   <= cfg_data_i[ultd_pkg::ZoneHourW-1:0];
        ultd_pkg::RegZoneMinutes: zone_minutes_q <= cfg_data_i[ultd_pkg::ZoneMinW-1:0];
        default: ;
      endcase
    end
  end

  assign req_data.utc_year   = req_i.utc_year;
  assign req_data.utc_month  = req_i.utc_month;
  assign req_data.utc_day    = req_i.utc_day;
  assign req_data.utc_hour   = req_i.utc_hour;
  assign req_data.utc_minute = req_i.utc_minute;
  assign req_data.dst_offset = req_i.dst_offset;

  ultd_time_add u_time_add (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (req_i.valid),
    .in_ready_o     (req_i.ready),
    .in_data_i      (req_data),
    .zone_hours_i   (zone_hours_q),
    .zone_minutes_i (zone_minutes_q),
    .out_valid_o    (mid_valid),
    .out_ready_i    (mid_ready),
    .out_data_o     (mid_data)
  );

  ultd_date_roll u_date_roll (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_data_i   (mid_data),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_data_o  (res_data)
  );

  assign res_o.local_year   = res_data.local_year;
  assign res_o.local_month  = res_data.local_month;
  assign res_o.local_day    = res_data.local_day;
  assign res_o.local_hour   = res_data.local_hour;
  assign res_o.local_minute = res_data.local_minute;

endmodule

`default_nettype wire
